>>> rtl/core/gcdlcm_pkg.sv
// ----------------------------------------------------------------------------
// gcdlcm_pkg
// shared widths and constants of the gcd / lcm unit
// ----------------------------------------------------------------------------
package gcdlcm_pkg;

  localparam int unsigned OPND_W    = 64;              // operand and divisor width
  localparam int unsigned LCM_W     = 63;              // lcm field width
  localparam int unsigned S_TDATA_W = 2 * OPND_W;      // operand_a, operand_b
  localparam int unsigned M_TDATA_W = 128;             // divisor, multiple, zero pad
  localparam int unsigned M_TUSER_W = 1;               // multiple_overflow

  localparam logic [LCM_W-1:0] LCM_MAX = {LCM_W{1'b1}};

endpackage

>>> rtl/core/gcd_lcm_unit.sv
// ----------------------------------------------------------------------------
// gcd_lcm_unit
// gcd and saturating lcm of two signed 64-bit operands on one shared adder
// ----------------------------------------------------------------------------
//
//  channel  | direction | tdata (low bit first)                 | tuser
//  ---------+-----------+---------------------------------------+-------------------
//  s_axis   | in        | operand_a[63:0], operand_b[127:64]    | -
//  m_axis   | out       | divisor[63:0], multiple[126:64], pad  | multiple_overflow
//
//  one transaction at a time: s_axis_tready_o is high only while the sequencer
//  is idle. when an operand is zero the sequencer goes from the magnitudes
//  straight to the result; otherwise it takes the magnitude of each operand,
//  runs a binary gcd loop (one shift, subtract or swap per cycle), restores
//  the common factors of two, sets up the divide, then runs 64 divide steps
//  and 64 multiply steps and hands over the result. all additions and
//  subtractions run through one 66-bit add/subtract unit.
//  the result sits in an output register, so a new transaction is accepted
//  while the previous result waits for m_axis_tready_i.
//  reset (rst_ni low, asynchronous) returns the sequencer to idle and drops
//  m_axis_tvalid_o; datapath registers are not reset.
//
module gcd_lcm_unit (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               s_axis_tvalid_i,
  output logic                               s_axis_tready_o,
  // operand_a [63:0], operand_b [127:64]
  input  logic [gcdlcm_pkg::S_TDATA_W-1:0]   s_axis_tdata_i,
  output logic                               m_axis_tvalid_o,
  input  logic                               m_axis_tready_i,
  // divisor [63:0], multiple [126:64], zero [127]
  output logic [gcdlcm_pkg::M_TDATA_W-1:0]   m_axis_tdata_o,
  // multiple_overflow [0]
  output logic [gcdlcm_pkg::M_TUSER_W-1:0]   m_axis_tuser_o
);

  import gcdlcm_pkg::*;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_ABS_A,
    ST_ABS_B,
    ST_GCD,
    ST_SHIFT,
    ST_DIV,
    ST_MUL,
    ST_FIN
  } state_e;

  state_e              state_q;
  logic [OPND_W-1:0]   a_q;       // |operand_a|
  logic [OPND_W-1:0]   b_q;       // |operand_b|
  logic [OPND_W-1:0]   x_q;       // gcd working value, then remainder / product high
  logic [OPND_W-1:0]   y_q;       // gcd working value, then quotient / product low
  logic [OPND_W-1:0]   g_q;       // gcd
  logic [5:0]          k_q;       // common factors of two
  logic [5:0]          cnt_q;     // divide / multiply step
  logic                ovf_q;

  logic                m_valid_q;
  logic [OPND_W-1:0]   m_div_q;
  logic [LCM_W-1:0]    m_lcm_q;
  logic                m_ovf_q;

  // shared add / subtract unit
  logic [OPND_W:0]     alu_a;
  logic [OPND_W:0]     alu_b;
  logic                alu_sub;
  logic [OPND_W+1:0]   alu_res;
  logic                borrow;

  logic                s_acc;
  logic                out_load;
  logic                cnt_last;
  logic [OPND_W-1:0]   mag_a;
  logic [OPND_W-1:0]   mag_b;
  logic [OPND_W-1:0]   prod_lo;
  logic                prod_ovf;

  always_comb begin
    alu_a   = '0;
    alu_b   = '0;
    alu_sub = 1'b1;
    case (state_q)
      ST_ABS_A: begin
        alu_b = {1'b0, x_q};
      end
      ST_ABS_B: begin
        alu_b = {1'b0, y_q};
      end
      ST_GCD: begin
        alu_a = {1'b0, x_q};
        alu_b = {1'b0, y_q};
      end
      ST_DIV: begin
        // shift the next dividend bit into the partial remainder, try g
        alu_a = {x_q, y_q[OPND_W-1]};
        alu_b = {1'b0, g_q};
      end
      ST_MUL: begin
        alu_a   = {1'b0, x_q};
        alu_b   = y_q[0] ? {1'b0, b_q} : '0;
        alu_sub = 1'b0;
      end
      default: begin
        alu_a = '0;
      end
    endcase
  end

  assign alu_res = alu_sub ? ({1'b0, alu_a} - {1'b0, alu_b})
                           : ({1'b0, alu_a} + {1'b0, alu_b});
  assign borrow  = alu_res[OPND_W+1];

  // two's complement magnitude, -2^63 maps to 2^63
  assign mag_a = x_q[OPND_W-1] ? alu_res[OPND_W-1:0] : x_q;
  assign mag_b = y_q[OPND_W-1] ? alu_res[OPND_W-1:0] : y_q;

  assign prod_lo  = {alu_res[0], y_q[OPND_W-1:1]};
  assign prod_ovf = (alu_res[OPND_W:1] != '0) || prod_lo[OPND_W-1];

  assign cnt_last = (cnt_q == '1);
  assign s_acc    = s_axis_tvalid_i && s_axis_tready_o;
  // result register takes a new transaction when empty or being drained
  assign out_load = (state_q == ST_FIN) && (!m_valid_q || m_axis_tready_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      m_valid_q <= 1'b0;
    end else begin
      if (out_load) begin
        m_valid_q <= 1'b1;
      end else if (m_axis_tready_i) begin
        m_valid_q <= 1'b0;
      end
      case (state_q)
        ST_IDLE: begin
          if (s_acc) begin
            x_q     <= s_axis_tdata_i[OPND_W-1:0];
            y_q     <= s_axis_tdata_i[2*OPND_W-1:OPND_W];
            k_q     <= '0;
            state_q <= ST_ABS_A;
          end
        end
        ST_ABS_A: begin
          a_q     <= mag_a;
          x_q     <= mag_a;
          state_q <= ST_ABS_B;
        end
        ST_ABS_B: begin
          b_q <= mag_b;
          if (a_q == '0 || mag_b == '0) begin
            // gcd is the other magnitude, lcm is zero
            g_q     <= a_q | mag_b;
            y_q     <= '0;
            ovf_q   <= 1'b0;
            state_q <= ST_FIN;
          end else begin
            y_q     <= mag_b;
            state_q <= ST_GCD;
          end
        end
        ST_GCD: begin
          if (!x_q[0] && !y_q[0]) begin
            x_q <= x_q >> 1;
            y_q <= y_q >> 1;
            k_q <= k_q + 6'd1;
          end else if (!x_q[0]) begin
            x_q <= x_q >> 1;
          end else if (!y_q[0]) begin
            y_q <= y_q >> 1;
          end else if (borrow) begin
            x_q <= y_q;
            y_q <= x_q;
          end else if (alu_res[OPND_W-1:0] == '0) begin
            g_q     <= y_q;
            state_q <= ST_SHIFT;
          end else begin
            x_q <= alu_res[OPND_W-1:0];
          end
        end
        ST_SHIFT: begin
          if (k_q != '0) begin
            g_q <= g_q << 1;
            k_q <= k_q - 6'd1;
          end else begin
            x_q     <= '0;
            y_q     <= a_q;
            cnt_q   <= '0;
            state_q <= ST_DIV;
          end
        end
        ST_DIV: begin
          y_q   <= {y_q[OPND_W-2:0], ~borrow};
          cnt_q <= cnt_q + 6'd1;
          if (cnt_last) begin
            // quotient |a| / g stays in y_q as the multiplier
            x_q     <= '0;
            state_q <= ST_MUL;
          end else begin
            x_q <= borrow ? alu_a[OPND_W-1:0] : alu_res[OPND_W-1:0];
          end
        end
        ST_MUL: begin
          x_q   <= alu_res[OPND_W:1];
          cnt_q <= cnt_q + 6'd1;
          if (cnt_last) begin
            ovf_q   <= prod_ovf;
            y_q     <= prod_ovf ? {1'b0, LCM_MAX} : {1'b0, prod_lo[LCM_W-1:0]};
            state_q <= ST_FIN;
          end else begin
            y_q <= prod_lo;
          end
        end
        ST_FIN: begin
          if (out_load) begin
            m_div_q <= g_q;
            m_lcm_q <= y_q[LCM_W-1:0];
            m_ovf_q <= ovf_q;
            state_q <= ST_IDLE;
          end
        end
        default: begin
          state_q <= ST_IDLE;
        end
      endcase
    end
  end

  assign s_axis_tready_o = (state_q == ST_IDLE);
  assign m_axis_tvalid_o = m_valid_q;
  assign m_axis_tdata_o  = {{(M_TDATA_W - OPND_W - LCM_W){1'b0}}, m_lcm_q, m_div_q};
  assign m_axis_tuser_o  = m_ovf_q;

endmodule

>>> rtl/core/gcdlcm_checker.sv
// ----------------------------------------------------------------------------
// gcdlcm_checker
// port-level assertions for the gcd / lcm unit
// ----------------------------------------------------------------------------
module gcdlcm_checker (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               s_axis_tvalid_i,
  input  logic                               s_axis_tready_o,
  // operand_a [63:0], operand_b [127:64]
  input  logic [gcdlcm_pkg::S_TDATA_W-1:0]   s_axis_tdata_i,
  input  logic                               m_axis_tvalid_o,
  input  logic                               m_axis_tready_i,
  // divisor [63:0], multiple [126:64], zero [127]
  input  logic [gcdlcm_pkg::M_TDATA_W-1:0]   m_axis_tdata_o,
  // multiple_overflow [0]
  input  logic [gcdlcm_pkg::M_TUSER_W-1:0]   m_axis_tuser_o
);

  import gcdlcm_pkg::*;

  logic s_acc;
  logic [OPND_W-1:0] div_f;
  logic [LCM_W-1:0]  lcm_f;

  assign s_acc = s_axis_tvalid_i && s_axis_tready_o;
  assign div_f = m_axis_tdata_o[OPND_W-1:0];
  assign lcm_f = m_axis_tdata_o[OPND_W+LCM_W-1:OPND_W];

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && !m_axis_tready_i |=>
      m_axis_tvalid_o && $stable(m_axis_tdata_o) && $stable(m_axis_tuser_o))
    else $error("result changed while stalled");

  // one transaction in flight
  a_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_acc |=> !s_axis_tready_o)
    else $error("input accepted while busy");

  // saturation shows the max lcm
  a_sat: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && m_axis_tuser_o[0] |-> lcm_f == LCM_MAX)
    else $error("overflow without saturated lcm");

  // both operands zero gives zero lcm and no overflow
  a_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && div_f == '0 |-> lcm_f == '0 && !m_axis_tuser_o[0])
    else $error("nonzero lcm with zero gcd");

endmodule

bind gcd_lcm_unit gcdlcm_checker u_gcdlcm_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .s_axis_tvalid_i (s_axis_tvalid_i),
  .s_axis_tready_o (s_axis_tready_o),
  .s_axis_tdata_i  (s_axis_tdata_i),
  .m_axis_tvalid_o (m_axis_tvalid_o),
  .m_axis_tready_i (m_axis_tready_i),
  .m_axis_tdata_o  (m_axis_tdata_o),
  .m_axis_tuser_o  (m_axis_tuser_o)
);
